// ----- rtl/arr_pkg.sv -----
`timescale 1ns / 1ps

package arr_pkg;

    // Default sizes of the dimension and fraction fields.
    localparam int unsigned DIM_BITS_DEF  = 14;
    localparam int unsigned FRAC_BITS_DEF = 16;

    // Fixed widths of the side outputs.
    localparam int unsigned BLANK_BITS = 4;
    localparam int unsigned PIXW_BITS  = 8;
    localparam int unsigned PIXH_BITS  = 7;

    // Standard-definition frame and the values it maps to.
    localparam int unsigned SD_WIDTH    = 720;
    localparam int unsigned SD_HEIGHT   = 576;
    localparam int unsigned SD_ASPECT_W = 4;
    localparam int unsigned SD_ASPECT_H = 3;
    localparam int unsigned SD_BLANK    = 9;
    localparam int unsigned SD_PIXEL_W  = 128;
    localparam int unsigned SD_PIXEL_H  = 117;

endpackage

// ----- rtl/arr_gcd.sv -----
`timescale 1ns / 1ps

// Binary GCD of two nonzero values, one shift or one compare-and-subtract per cycle.
module arr_gcd #(
    parameter int unsigned DIM_BITS = arr_pkg::DIM_BITS_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  logic [DIM_BITS-1:0] op_a,
    input  logic [DIM_BITS-1:0] op_b,
    output logic                done,
    output logic [DIM_BITS-1:0] gcd
);

    localparam int unsigned TW_BITS = (DIM_BITS > 1) ? $clog2(DIM_BITS) : 1;

    typedef enum logic [1:0] {
        G_IDLE,
        G_TWOS,
        G_AODD,
        G_LOOP
    } gcd_state_t;

    gcd_state_t          state_reg;
    logic [DIM_BITS-1:0] a_reg;
    logic [DIM_BITS-1:0] b_reg;
    logic [TW_BITS-1:0]  twos_reg;
    logic                done_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= G_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            case (state_reg)
                G_IDLE:
                begin
                    if (start)
                    begin
                        a_reg     <= op_a;
                        b_reg     <= op_b;
                        twos_reg  <= '0;
                        state_reg <= G_TWOS;
                    end
                end
                G_TWOS:
                begin
                    // Strip the common factors of two and count them.
                    if (!a_reg[0] && !b_reg[0])
                    begin
                        a_reg    <= a_reg >> 1;
                        b_reg    <= b_reg >> 1;
                        twos_reg <= twos_reg + 1'b1;
                    end
                    else
                    begin
                        state_reg <= G_AODD;
                    end
                end
                G_AODD:
                begin
                    if (!a_reg[0])
                    begin
                        a_reg <= a_reg >> 1;
                    end
                    else
                    begin
                        state_reg <= G_LOOP;
                    end
                end
                G_LOOP:
                begin
                    // a stays odd; b is reduced until it reaches zero.
                    if (b_reg == '0)
                    begin
                        done_reg  <= 1'b1;
                        state_reg <= G_IDLE;
                    end
                    else if (!b_reg[0])
                    begin
                        b_reg <= b_reg >> 1;
                    end
                    else if (a_reg > b_reg)
                    begin
                        a_reg <= b_reg;
                        b_reg <= a_reg - b_reg;
                    end
                    else
                    begin
                        b_reg <= b_reg - a_reg;
                    end
                end
                default:
                begin
                    state_reg <= G_IDLE;
                end
            endcase
        end
    end

    assign done = done_reg;
    assign gcd  = a_reg << twos_reg;

endmodule

// ----- rtl/arr_div.sv -----
`timescale 1ns / 1ps

// Restoring divider, one quotient bit per cycle. The dividend is taken MSB first,
// so a run of fewer steps than the dividend width divides its upper bits only.
module arr_div #(
    parameter int unsigned DIM_BITS  = arr_pkg::DIM_BITS_DEF,
    parameter int unsigned FRAC_BITS = arr_pkg::FRAC_BITS_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    input  logic [DIM_BITS+FRAC_BITS-1:0]       dividend,
    input  logic [DIM_BITS-1:0]                 divisor,
    input  logic [$clog2(DIM_BITS+FRAC_BITS+1)-1:0] steps,
    output logic                                done,
    output logic [DIM_BITS+FRAC_BITS-1:0]       quotient
);

    localparam int unsigned QW      = DIM_BITS + FRAC_BITS;
    localparam int unsigned CNT_BITS = $clog2(QW + 1);

    logic [QW-1:0]       dvd_reg;
    logic [DIM_BITS-1:0] dsr_reg;
    logic [DIM_BITS-1:0] rem_reg;
    logic [CNT_BITS-1:0] cnt_reg;
    logic                busy_reg;
    logic                done_reg;

    logic [DIM_BITS:0]   shifted;
    logic [DIM_BITS:0]   diff;
    logic                fits;

    always_comb
    begin
        shifted = {rem_reg, dvd_reg[QW-1]};
        diff    = shifted - {1'b0, dsr_reg};
        fits    = (shifted >= {1'b0, dsr_reg});
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                dvd_reg  <= dividend;
                dsr_reg  <= divisor;
                rem_reg  <= '0;
                cnt_reg  <= steps;
                busy_reg <= 1'b1;
            end
            else if (busy_reg)
            begin
                // The remainder stays below the divisor, so DIM_BITS hold it.
                rem_reg <= fits ? diff[DIM_BITS-1:0] : shifted[DIM_BITS-1:0];
                dvd_reg <= {dvd_reg[QW-2:0], fits};
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CNT_BITS'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign done     = done_reg;
    assign quotient = dvd_reg;

endmodule

// ----- rtl/aspect_ratio_reducer.sv -----
`timescale 1ns / 1ps
// A zero dimension or the 720x576 frame goes from idle straight to the output state; any
// other frame first runs the binary GCD and then three divisions on the shared divider.
// The output state loads the response once the output register is empty or being emptied.
// One request is in work at a time; the next one is taken in the cycle its predecessor's
// response can first be taken. Reset clears all control state and the output valid.
module aspect_ratio_reducer #(
    parameter int unsigned DIM_BITS  = arr_pkg::DIM_BITS_DEF,
    parameter int unsigned FRAC_BITS = arr_pkg::FRAC_BITS_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              req_valid,
    output logic                              req_ready,
    input  logic [DIM_BITS-1:0]               frame_width,
    input  logic [DIM_BITS-1:0]               frame_height,
    output logic                              rsp_valid,
    input  logic                              rsp_ready,
    output logic [DIM_BITS-1:0]               aspect_w,
    output logic [DIM_BITS-1:0]               aspect_h,
    output logic [DIM_BITS+FRAC_BITS-1:0]     ratio_fixed,
    output logic [arr_pkg::BLANK_BITS-1:0]    blank_count,
    output logic [arr_pkg::PIXW_BITS-1:0]     pixel_w,
    output logic [arr_pkg::PIXH_BITS-1:0]     pixel_h,
    output logic                              zero_error
);

    localparam int unsigned QW       = DIM_BITS + FRAC_BITS;
    localparam int unsigned CNT_BITS = $clog2(QW + 1);

    // Fixed-point ratio of the standard frame, worked out from constants.
    localparam int unsigned SD_RATIO = (arr_pkg::SD_ASPECT_W << FRAC_BITS) /
                                       arr_pkg::SD_ASPECT_H;

    // Sequencer: except for zero and standard frames, the GCD runs first, then the shared
    // divider is used for width/gcd, height/gcd and the reduced pair's fixed-point ratio.
    typedef enum logic [2:0] {
        S_IDLE,
        S_GCD,
        S_DIVW,
        S_DIVH,
        S_RATIO,
        S_OUT
    } seq_state_t;

    seq_state_t                   state_reg;

    // Working copy of the request and the partial results.
    logic [DIM_BITS-1:0]          w_reg;
    logic [DIM_BITS-1:0]          h_reg;
    logic [DIM_BITS-1:0]          aw_reg;
    logic [DIM_BITS-1:0]          ah_reg;
    logic [QW-1:0]                ratio_reg;
    logic [arr_pkg::BLANK_BITS-1:0] blank_reg;
    logic [arr_pkg::PIXW_BITS-1:0]  pw_reg;
    logic [arr_pkg::PIXH_BITS-1:0]  ph_reg;
    logic                         zero_reg;

    // Operands handed to the GCD unit and the divider.
    logic                         gcd_start_reg;
    logic                         div_start_reg;
    logic [QW-1:0]                div_dividend_reg;
    logic [DIM_BITS-1:0]          div_divisor_reg;
    logic [CNT_BITS-1:0]          div_steps_reg;

    // Output register; it holds a finished response while the next request is taken.
    logic                         rsp_valid_reg;
    logic [DIM_BITS-1:0]          rsp_aw_reg;
    logic [DIM_BITS-1:0]          rsp_ah_reg;
    logic [QW-1:0]                rsp_ratio_reg;
    logic [arr_pkg::BLANK_BITS-1:0] rsp_blank_reg;
    logic [arr_pkg::PIXW_BITS-1:0]  rsp_pw_reg;
    logic [arr_pkg::PIXH_BITS-1:0]  rsp_ph_reg;
    logic                         rsp_zero_reg;

    logic                         gcd_done;
    logic [DIM_BITS-1:0]          gcd_value;
    logic                         div_done;
    logic [QW-1:0]                div_quotient;
    logic                         req_take;
    logic                         is_zero;
    logic                         is_sd;

    arr_gcd #(
        .DIM_BITS (DIM_BITS)
    ) u_gcd (
        .clk   (clk),
        .rst_n (rst_n),
        .start (gcd_start_reg),
        .op_a  (w_reg),
        .op_b  (h_reg),
        .done  (gcd_done),
        .gcd   (gcd_value)
    );

    arr_div #(
        .DIM_BITS  (DIM_BITS),
        .FRAC_BITS (FRAC_BITS)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start_reg),
        .dividend (div_dividend_reg),
        .divisor  (div_divisor_reg),
        .steps    (div_steps_reg),
        .done     (div_done),
        .quotient (div_quotient)
    );

    assign req_ready = (state_reg == S_IDLE);
    assign req_take  = req_valid && req_ready;
    assign is_zero   = (frame_width == '0) || (frame_height == '0);
    // With a narrow DIM_BITS the standard frame cannot be represented and never matches.
    assign is_sd     = (32'(frame_width) == arr_pkg::SD_WIDTH) &&
                       (32'(frame_height) == arr_pkg::SD_HEIGHT);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            gcd_start_reg <= 1'b0;
            div_start_reg <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            gcd_start_reg <= 1'b0;
            div_start_reg <= 1'b0;

            if (rsp_valid_reg && rsp_ready)
            begin
                rsp_valid_reg <= 1'b0;
            end

            case (state_reg)
                S_IDLE:
                begin
                    if (req_take)
                    begin
                        w_reg     <= frame_width;
                        h_reg     <= frame_height;
                        blank_reg <= '0;
                        pw_reg    <= arr_pkg::PIXW_BITS'(1);
                        ph_reg    <= arr_pkg::PIXH_BITS'(1);
                        zero_reg  <= 1'b0;
                        if (is_zero)
                        begin
                            // Every field but the error flag reads zero.
                            aw_reg    <= '0;
                            ah_reg    <= '0;
                            ratio_reg <= '0;
                            pw_reg    <= '0;
                            ph_reg    <= '0;
                            zero_reg  <= 1'b1;
                            state_reg <= S_OUT;
                        end
                        else if (is_sd)
                        begin
                            // The standard frame skips the GCD and the divider and
                            // uses fixed values.
                            aw_reg    <= DIM_BITS'(arr_pkg::SD_ASPECT_W);
                            ah_reg    <= DIM_BITS'(arr_pkg::SD_ASPECT_H);
                            ratio_reg <= QW'(SD_RATIO);
                            blank_reg <= arr_pkg::BLANK_BITS'(arr_pkg::SD_BLANK);
                            pw_reg    <= arr_pkg::PIXW_BITS'(arr_pkg::SD_PIXEL_W);
                            ph_reg    <= arr_pkg::PIXH_BITS'(arr_pkg::SD_PIXEL_H);
                            state_reg <= S_OUT;
                        end
                        else
                        begin
                            gcd_start_reg <= 1'b1;
                            state_reg     <= S_GCD;
                        end
                    end
                end
                S_GCD:
                begin
                    if (gcd_done)
                    begin
                        // Width over the GCD: the width sits in the top bits, so
                        // DIM_BITS steps leave the integer quotient in the low bits.
                        div_dividend_reg <= {w_reg, {FRAC_BITS{1'b0}}};
                        div_divisor_reg  <= gcd_value;
                        div_steps_reg    <= CNT_BITS'(DIM_BITS);
                        div_start_reg    <= 1'b1;
                        state_reg        <= S_DIVW;
                    end
                end
                S_DIVW:
                begin
                    if (div_done)
                    begin
                        aw_reg           <= div_quotient[DIM_BITS-1:0];
                        div_dividend_reg <= {h_reg, {FRAC_BITS{1'b0}}};
                        div_start_reg    <= 1'b1;
                        state_reg        <= S_DIVH;
                    end
                end
                S_DIVH:
                begin
                    if (div_done)
                    begin
                        ah_reg           <= div_quotient[DIM_BITS-1:0];
                        div_dividend_reg <= {aw_reg, {FRAC_BITS{1'b0}}};
                        div_divisor_reg  <= div_quotient[DIM_BITS-1:0];
                        div_steps_reg    <= CNT_BITS'(QW);
                        div_start_reg    <= 1'b1;
                        state_reg        <= S_RATIO;
                    end
                end
                S_RATIO:
                begin
                    if (div_done)
                    begin
                        ratio_reg <= div_quotient;
                        state_reg <= S_OUT;
                    end
                end
                S_OUT:
                begin
                    // Load the output register once it is empty or being emptied.
                    if (!rsp_valid_reg || rsp_ready)
                    begin
                        rsp_valid_reg <= 1'b1;
                        rsp_aw_reg    <= aw_reg;
                        rsp_ah_reg    <= ah_reg;
                        rsp_ratio_reg <= ratio_reg;
                        rsp_blank_reg <= blank_reg;
                        rsp_pw_reg    <= pw_reg;
                        rsp_ph_reg    <= ph_reg;
                        rsp_zero_reg  <= zero_reg;
                        state_reg     <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign rsp_valid   = rsp_valid_reg;
    assign aspect_w    = rsp_aw_reg;
    assign aspect_h    = rsp_ah_reg;
    assign ratio_fixed = rsp_ratio_reg;
    assign blank_count = rsp_blank_reg;
    assign pixel_w     = rsp_pw_reg;
    assign pixel_h     = rsp_ph_reg;
    assign zero_error  = rsp_zero_reg;

endmodule

// ----- dv/tb_top.sv -----
`timescale 1ns / 1ps

module tb_top;

    // Block configuration under test.
    localparam int unsigned DIM_BITS  = arr_pkg::DIM_BITS_DEF;
    localparam int unsigned FRAC_BITS = arr_pkg::FRAC_BITS_DEF;
    localparam int unsigned DIM_MAX   = (1 << DIM_BITS) - 1;

    // Stimulus volume and the receiver hold-off used to back up the block.
    localparam int unsigned RANDOM_FRAMES = 1250;
    localparam int unsigned HOLD_AT_RSP   = 100;
    localparam int unsigned HOLD_CYCLES   = 600;

    // Extra cycles run once the last result has come, to catch anything still in flight.
    localparam int unsigned DRAIN_CYCLES  = 250;

    typedef logic [DIM_BITS-1:0]           dim_t;
    typedef logic [DIM_BITS+FRAC_BITS-1:0] ratio_t;

    typedef struct packed {
        dim_t width;
        dim_t height;
    } frame_t;

    typedef struct packed {
        dim_t                            aspect_w;
        dim_t                            aspect_h;
        ratio_t                          ratio_fixed;
        logic [arr_pkg::BLANK_BITS-1:0]  blank_count;
        logic [arr_pkg::PIXW_BITS-1:0]   pixel_w;
        logic [arr_pkg::PIXH_BITS-1:0]   pixel_h;
        logic                            zero_error;
    } aspect_t;

    logic   clk          = 1'b0;
    logic   rst_n        = 1'b0;
    logic   req_valid    = 1'b0;
    logic   req_ready;
    dim_t   frame_width  = '0;
    dim_t   frame_height = '0;
    logic   rsp_valid;
    logic   rsp_ready    = 1'b0;
    dim_t   aspect_w;
    dim_t   aspect_h;
    ratio_t ratio_fixed;
    logic [arr_pkg::BLANK_BITS-1:0] blank_count;
    logic [arr_pkg::PIXW_BITS-1:0]  pixel_w;
    logic [arr_pkg::PIXH_BITS-1:0]  pixel_h;
    logic   zero_error;

    frame_t  frames_to_send[$];
    aspect_t expected_aspects[$];

    int unsigned total_frames = 0;
    int unsigned frames_sent  = 0;
    int unsigned aspects_seen = 0;
    int unsigned error_count  = 0;

    // Receiver hold-off state, owned by its own process.
    logic        hold_off      = 1'b0;
    int unsigned hold_left     = 0;
    bit          hold_done     = 1'b0;

    frame_t      next_frame;
    aspect_t     actual_aspect;
    aspect_t     wanted_aspect;

    aspect_ratio_reducer #(
        .DIM_BITS  (DIM_BITS),
        .FRAC_BITS (FRAC_BITS)
    ) uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .req_valid    (req_valid),
        .req_ready    (req_ready),
        .frame_width  (frame_width),
        .frame_height (frame_height),
        .rsp_valid    (rsp_valid),
        .rsp_ready    (rsp_ready),
        .aspect_w     (aspect_w),
        .aspect_h     (aspect_h),
        .ratio_fixed  (ratio_fixed),
        .blank_count  (blank_count),
        .pixel_w      (pixel_w),
        .pixel_h      (pixel_h),
        .zero_error   (zero_error)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Expected reduction of one frame. The divisor is found with Euclid's
    // remainder loop, which yields the same GCD as the block's binary method.
    function automatic aspect_t predict_aspect(frame_t f);
        aspect_t     r;
        logic [31:0] a;
        logic [31:0] b;
        logic [31:0] rem;
        logic [63:0] scaled;
        r = '0;
        if (f.width == '0 || f.height == '0)
        begin
            r.zero_error = 1'b1;
        end
        else
        begin
            if (f.width == dim_t'(arr_pkg::SD_WIDTH) && f.height == dim_t'(arr_pkg::SD_HEIGHT))
            begin
                r.aspect_w    = dim_t'(arr_pkg::SD_ASPECT_W);
                r.aspect_h    = dim_t'(arr_pkg::SD_ASPECT_H);
                r.blank_count = arr_pkg::BLANK_BITS'(arr_pkg::SD_BLANK);
                r.pixel_w     = arr_pkg::PIXW_BITS'(arr_pkg::SD_PIXEL_W);
                r.pixel_h     = arr_pkg::PIXH_BITS'(arr_pkg::SD_PIXEL_H);
            end
            else
            begin
                a = 32'(f.width);
                b = 32'(f.height);
                while (b != 0)
                begin
                    rem = a % b;
                    a   = b;
                    b   = rem;
                end
                r.aspect_w    = dim_t'(32'(f.width) / a);
                r.aspect_h    = dim_t'(32'(f.height) / a);
                r.blank_count = '0;
                r.pixel_w     = arr_pkg::PIXW_BITS'(1);
                r.pixel_h     = arr_pkg::PIXH_BITS'(1);
            end
            scaled        = 64'(r.aspect_w) << FRAC_BITS;
            r.ratio_fixed = ratio_t'(scaled / 64'(r.aspect_h));
        end
        return r;
    endfunction

    function automatic frame_t make_frame(int unsigned w, int unsigned h);
        frame_t f;
        f.width  = dim_t'(w);
        f.height = dim_t'(h);
        return f;
    endfunction

    // Random frames are weighted toward shapes that exercise the reduction:
    // shared factors, long runs of trailing zeros, zero dimensions, the standard-definition
    // frame and its neighbors, with plain random values for full bit coverage.
    function automatic frame_t random_frame();
        int unsigned pick;
        int unsigned a;
        int unsigned b;
        int unsigned k;
        frame_t      f;
        pick = $urandom_range(99);
        if (pick < 40)
        begin
            f = make_frame($urandom, $urandom);
        end
        else if (pick < 58)
        begin
            f = make_frame($urandom_range(1, 64), $urandom_range(1, 64));
        end
        else if (pick < 76)
        begin
            a = $urandom_range(1, 32);
            b = $urandom_range(1, 32);
            k = $urandom_range(1, DIM_MAX / ((a > b) ? a : b));
            f = make_frame(a * k, b * k);
        end
        else if (pick < 88)
        begin
            f = make_frame(($urandom_range(0, 63) * 2 + 1) << $urandom_range(0, 7),
                           ($urandom_range(0, 63) * 2 + 1) << $urandom_range(0, 7));
        end
        else if (pick < 93)
        begin
            if ($urandom_range(1) == 1)
                f = make_frame(0, $urandom);
            else
                f = make_frame($urandom, 0);
        end
        else if (pick < 96)
        begin
            f = make_frame(arr_pkg::SD_WIDTH, arr_pkg::SD_HEIGHT);
        end
        else
        begin
            f = make_frame(arr_pkg::SD_WIDTH + $urandom_range(2) - 1,
                           arr_pkg::SD_HEIGHT + $urandom_range(2) - 1);
        end
        return f;
    endfunction

    task automatic check_field(string field, longint unsigned want, longint unsigned got);
        if (want != got)
        begin
            $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
            error_count++;
        end
    endtask

    // Idle percentages for the three phases: light sender gaps with heavy receiver
    // stalls, then the two swapped, then back to back.
    function automatic int unsigned send_idle_pct(int unsigned done);
        if (done < total_frames / 3)
            return 28;
        else if (done < (2 * total_frames) / 3)
            return 71;
        return 0;
    endfunction

    function automatic int unsigned recv_idle_pct(int unsigned done);
        if (done < total_frames / 3)
            return 71;
        else if (done < (2 * total_frames) / 3)
            return 28;
        return 0;
    endfunction

    // Request driver. A frame is predicted when its request is taken, and a
    // held request stays untouched until the block accepts it.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_valid    <= 1'b0;
            frame_width  <= '0;
            frame_height <= '0;
        end
        else
        begin
            if (req_valid && req_ready)
            begin
                expected_aspects.push_back(predict_aspect(make_frame(32'(frame_width),
                                                                     32'(frame_height))));
                frames_sent++;
            end
            if (!req_valid || req_ready)
            begin
                if (frames_to_send.size() > 0 &&
                    $urandom_range(99) >= send_idle_pct(frames_sent))
                begin
                    next_frame    = frames_to_send.pop_front();
                    req_valid    <= 1'b1;
                    frame_width  <= next_frame.width;
                    frame_height <= next_frame.height;
                end
                else
                begin
                    req_valid <= 1'b0;
                end
            end
        end
    end

    // Once, early in the run, the receiver refuses results for a long stretch
    // so that the block backs up and stops taking requests.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_off  <= 1'b0;
            hold_left  = 0;
        end
        else if (hold_left > 0)
        begin
            hold_left--;
            hold_off <= (hold_left > 0);
        end
        else if (!hold_done && aspects_seen >= HOLD_AT_RSP)
        begin
            hold_done  = 1'b1;
            hold_left  = HOLD_CYCLES;
            hold_off  <= 1'b1;
        end
    end

    // Result monitor: every accepted result is compared with the oldest
    // prediction, field by field.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_ready <= 1'b0;
        end
        else
        begin
            if (rsp_valid && rsp_ready)
            begin
                actual_aspect = '{aspect_w, aspect_h, ratio_fixed, blank_count,
                                  pixel_w, pixel_h, zero_error};
                if (expected_aspects.size() == 0)
                begin
                    $display("%0t ns: result with no request pending, expected none, actual %p",
                             $time, actual_aspect);
                    error_count++;
                end
                else
                begin
                    wanted_aspect = expected_aspects.pop_front();
                    check_field("aspect_w", 64'(wanted_aspect.aspect_w),
                                64'(actual_aspect.aspect_w));
                    check_field("aspect_h", 64'(wanted_aspect.aspect_h),
                                64'(actual_aspect.aspect_h));
                    check_field("ratio_fixed", 64'(wanted_aspect.ratio_fixed),
                                64'(actual_aspect.ratio_fixed));
                    check_field("blank_count", 64'(wanted_aspect.blank_count),
                                64'(actual_aspect.blank_count));
                    check_field("pixel_w", 64'(wanted_aspect.pixel_w),
                                64'(actual_aspect.pixel_w));
                    check_field("pixel_h", 64'(wanted_aspect.pixel_h),
                                64'(actual_aspect.pixel_h));
                    check_field("zero_error", 64'(wanted_aspect.zero_error),
                                64'(actual_aspect.zero_error));
                end
                aspects_seen++;
            end
            if (hold_off)
                rsp_ready <= 1'b0;
            else
                rsp_ready <= ($urandom_range(99) >= recv_idle_pct(aspects_seen));
        end
    end

    // Directed frames first: zero dimensions, the standard-definition frame
    // and its near misses, field extremes and common video formats.
    initial
    begin
        frames_to_send.push_back(make_frame(0, 0));
        frames_to_send.push_back(make_frame(0, 5));
        frames_to_send.push_back(make_frame(5, 0));
        frames_to_send.push_back(make_frame(DIM_MAX, 0));
        frames_to_send.push_back(make_frame(0, DIM_MAX));
        frames_to_send.push_back(make_frame(arr_pkg::SD_WIDTH, arr_pkg::SD_HEIGHT));
        frames_to_send.push_back(make_frame(arr_pkg::SD_HEIGHT, arr_pkg::SD_WIDTH));
        frames_to_send.push_back(make_frame(arr_pkg::SD_WIDTH + 1, arr_pkg::SD_HEIGHT));
        frames_to_send.push_back(make_frame(arr_pkg::SD_WIDTH, arr_pkg::SD_HEIGHT + 1));
        frames_to_send.push_back(make_frame(2 * arr_pkg::SD_WIDTH, 2 * arr_pkg::SD_HEIGHT));
        frames_to_send.push_back(make_frame(1, 1));
        frames_to_send.push_back(make_frame(DIM_MAX, DIM_MAX));
        frames_to_send.push_back(make_frame(1, DIM_MAX));
        frames_to_send.push_back(make_frame(DIM_MAX, 1));
        frames_to_send.push_back(make_frame(1920, 1080));
        frames_to_send.push_back(make_frame(1280, 720));
        frames_to_send.push_back(make_frame(8192, 4096));
        frames_to_send.push_back(make_frame(8192, 1));
        frames_to_send.push_back(make_frame(4096, 6144));
        frames_to_send.push_back(make_frame(12288, 3));
        frames_to_send.push_back(make_frame(3, 12288));
        frames_to_send.push_back(make_frame(DIM_MAX - 1, DIM_MAX / 2));
        frames_to_send.push_back(make_frame(9973, 9967));
        repeat (RANDOM_FRAMES)
            frames_to_send.push_back(random_frame());
        total_frames = frames_to_send.size();

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        while (frames_to_send.size() > 0 || req_valid || expected_aspects.size() > 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (expected_aspects.size() > 0)
        begin
            $display("%0t ns: results missing, expected %0d more, actual 0",
                     $time, expected_aspects.size());
            error_count++;
        end

        if (error_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

    // Far beyond the slowest legal run, including the long receiver hold-off.
    initial
    begin
        #10_000_000;
        $display("FAILURE");
        $finish;
    end

endmodule

// ----- files.f -----
rtl/arr_pkg.sv
rtl/arr_gcd.sv
rtl/arr_div.sv
rtl/aspect_ratio_reducer.sv
dv/tb_top.sv
